[design/dshs_pkg.sv]
// ----------------------------------------------------------------------------
// dshs_pkg
// Shared codes, switch patterns and types for the dual source harvest selector.
// ----------------------------------------------------------------------------
package dshs_pkg;

  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned DIFF_W  = LEVEL_W + 1;
  localparam int unsigned RUN_W   = 12;
  localparam int unsigned SEC_W   = RUN_W + 1;
  localparam int unsigned PAT_W   = 6;

  // item kinds
  localparam logic [1:0] KIND_CAP    = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // phase codes as shown on phase_now
  localparam logic [1:0] PH_EVAL_ONE = 2'd0;
  localparam logic [1:0] PH_EVAL_TWO = 2'd1;
  localparam logic [1:0] PH_RUN      = 2'd2;

  // switch patterns: bit 0 src1 switch, 1 src1 block, 2 src2 switch,
  // 3 src2 block, 4 eval cap, 5 store cap
  localparam logic [PAT_W-1:0] PAT_EVAL_ONE = 6'h19;
  localparam logic [PAT_W-1:0] PAT_EVAL_TWO = 6'h16;
  localparam logic [PAT_W-1:0] PAT_ONE_ONLY = 6'h29;
  localparam logic [PAT_W-1:0] PAT_TWO_ONLY = 6'h26;
  localparam logic [PAT_W-1:0] PAT_BOTH     = 6'h25;

  localparam logic [RUN_W-1:0] RUN_RESET = 12'd300;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [1:0]       phase;
    logic             primary;
  } res_t;

endpackage

[design/dshs_core.sv]
// ----------------------------------------------------------------------------
// dshs_core
// Phase sequencing, source evaluation and run-time switch decisions.
// Updates state on an accepted beat and presents that beat's result.
// ----------------------------------------------------------------------------
module dshs_core
  import dshs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         kind,
  input  logic [LEVEL_W-1:0] cap_high,
  input  logic [LEVEL_W-1:0] cap_low,
  input  logic [LEVEL_W-1:0] src1_level,
  input  logic [LEVEL_W-1:0] src2_level,
  input  logic [LEVEL_W-1:0] ref_level,
  input  logic [RUN_W-1:0]   run_seconds,
  output res_t               res
);

  logic [1:0]         phase_r, phase_nxt;
  logic [DIFF_W-1:0]  first_diff_r, first_diff_nxt;
  logic               primary_r, primary_nxt;
  logic               one_on_r, one_on_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [PAT_W-1:0]   pat_r, pat_nxt;

  logic signed [DIFF_W-1:0] diff, d1, d2, d21;
  logic [SEC_W-1:0]         sec_inc;
  logic                     join_src;

  function automatic logic same_sign(logic signed [DIFF_W-1:0] a,
                                     logic signed [DIFF_W-1:0] b);
    logic a_pos, b_pos;
    a_pos = !a[DIFF_W-1] && (a != '0);
    b_pos = !b[DIFF_W-1] && (b != '0);
    return (a_pos && b_pos) || (a[DIFF_W-1] && b[DIFF_W-1]);
  endfunction

  assign diff = $signed({1'b0, cap_high}) - $signed({1'b0, cap_low});
  assign d1   = $signed({1'b0, src1_level}) - $signed({1'b0, ref_level});
  assign d2   = $signed({1'b0, src2_level}) - $signed({1'b0, ref_level});
  assign d21  = $signed({1'b0, src2_level}) - $signed({1'b0, src1_level});
  assign sec_inc = sec_r + SEC_W'(1);
  assign join_src = one_on_r ? same_sign(d21, d1) : same_sign(d2, d1);

  always_comb begin
    phase_nxt      = phase_r;
    first_diff_nxt = first_diff_r;
    primary_nxt    = primary_r;
    one_on_nxt     = one_on_r;
    sec_nxt        = sec_r;
    pat_nxt        = pat_r;
    case (phase_r)
      PH_EVAL_ONE: begin
        if (kind == KIND_CAP) begin
          first_diff_nxt = diff;
          phase_nxt      = PH_EVAL_TWO;
          pat_nxt        = PAT_EVAL_TWO;
          one_on_nxt     = 1'b0;
        end
      end
      PH_EVAL_TWO: begin
        if (kind == KIND_CAP) begin
          if ($signed(first_diff_r) > diff) begin
            primary_nxt = 1'b1;
            pat_nxt     = PAT_ONE_ONLY;
            one_on_nxt  = 1'b1;
          end else begin
            primary_nxt = 1'b0;
            pat_nxt     = PAT_TWO_ONLY;
            one_on_nxt  = 1'b0;
          end
          phase_nxt = PH_RUN;
          sec_nxt   = '0;
        end
      end
      PH_RUN: begin
        if (kind == KIND_SAMPLE) begin
          if (primary_r) begin
            pat_nxt    = same_sign(d1, d21) ? PAT_BOTH : PAT_ONE_ONLY;
            one_on_nxt = 1'b1;
          end else begin
            pat_nxt    = join_src ? PAT_BOTH : PAT_TWO_ONLY;
            one_on_nxt = join_src;
          end
        end else if (kind == KIND_TICK) begin
          if (sec_inc > {1'b0, run_seconds}) begin
            sec_nxt    = '0;
            phase_nxt  = PH_EVAL_ONE;
            pat_nxt    = PAT_EVAL_ONE;
            one_on_nxt = 1'b1;
          end else begin
            sec_nxt = sec_inc;
          end
        end
      end
      default: begin
        phase_nxt  = PH_EVAL_ONE;
        pat_nxt    = PAT_EVAL_ONE;
        one_on_nxt = 1'b1;
      end
    endcase
  end

  assign res.pattern = pat_nxt;
  assign res.phase   = phase_nxt;
  assign res.primary = primary_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_EVAL_ONE;
      first_diff_r <= '0;
      primary_r    <= 1'b0;
      one_on_r     <= 1'b1;
      sec_r        <= '0;
      pat_r        <= PAT_EVAL_ONE;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      first_diff_r <= first_diff_nxt;
      primary_r    <= primary_nxt;
      one_on_r     <= one_on_nxt;
      sec_r        <= sec_nxt;
      pat_r        <= pat_nxt;
    end
  end

endmodule

[design/dual_source_harvest_selector_top.sv]
// ----------------------------------------------------------------------------
// dual_source_harvest_selector_top
// Switch controller for a two-source energy harvester.
// ----------------------------------------------------------------------------
// One beat in, one result beat out. A beat is taken every cycle unless
// in_stall is high; its result goes to the result register, or to the skid
// register while the output is held. This two-entry buffer keeps taking a
// beat while the downstream side stalls; in_stall rises only once both are
// full. The user must write run_seconds through the cfg port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dual_source_harvest_selector_top
  import dshs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RUN_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [LEVEL_W-1:0] in_cap_high,
  input  logic [LEVEL_W-1:0] in_cap_low,
  input  logic [LEVEL_W-1:0] in_src1_level,
  input  logic [LEVEL_W-1:0] in_src2_level,
  input  logic [LEVEL_W-1:0] in_ref_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_src1_switch,
  output logic               out_src1_block,
  output logic               out_src2_switch,
  output logic               out_src2_block,
  output logic               out_eval_cap_switch,
  output logic               out_store_cap_switch,
  output logic [1:0]         out_phase_now,
  output logic               out_primary_is_one
);

  logic [RUN_W-1:0] run_sec_r;
  logic             out_vld_r, skid_vld_r;
  res_t             out_res_r, skid_res_r;
  res_t             res;
  logic             in_acc, out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_vld_r;
  assign in_acc    = in_valid && !skid_vld_r;
  assign out_take  = out_vld_r && !out_stall;

  dshs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .kind        (in_kind),
    .cap_high    (in_cap_high),
    .cap_low     (in_cap_low),
    .src1_level  (in_src1_level),
    .src2_level  (in_src2_level),
    .ref_level   (in_ref_level),
    .run_seconds (run_sec_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sec_r <= RUN_RESET;
    end else if (cfg_valid) begin
      run_sec_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_take) begin
          out_res_r  <= skid_res_r;
          skid_vld_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_vld_r || out_take) begin
          out_res_r <= res;
          out_vld_r <= 1'b1;
        end else begin
          skid_res_r <= res;
          skid_vld_r <= 1'b1;
        end
      end else if (out_take) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_vld_r;
  assign out_src1_switch      = out_res_r.pattern[0];
  assign out_src1_block       = out_res_r.pattern[1];
  assign out_src2_switch      = out_res_r.pattern[2];
  assign out_src2_block       = out_res_r.pattern[3];
  assign out_eval_cap_switch  = out_res_r.pattern[4];
  assign out_store_cap_switch = out_res_r.pattern[5];
  assign out_phase_now        = out_res_r.phase;
  assign out_primary_is_one   = out_res_r.primary;

endmodule

[design/dshs_checker.sv]
// ----------------------------------------------------------------------------
// dshs_checker
// Port-level checks for the dual source harvest selector, bound to the top.
// ----------------------------------------------------------------------------
module dshs_checker
  import dshs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_src1_switch,
  input logic               out_src1_block,
  input logic               out_src2_switch,
  input logic               out_src2_block,
  input logic               out_eval_cap_switch,
  input logic               out_store_cap_switch,
  input logic [1:0]         out_phase_now
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_phase_now)
      && $stable(out_src1_switch) && $stable(out_src2_switch))
    else $error("stalled result beat changed");

  // harvesting always keeps the storage capacitor connected, eval cap open
  a_run_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase_now == PH_RUN |-> out_store_cap_switch && !out_eval_cap_switch)
    else $error("storage switch open while harvesting");

  // source one evaluation pattern
  a_eval_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase_now == PH_EVAL_ONE |-> out_src1_switch && out_src2_block
      && out_eval_cap_switch && !out_store_cap_switch && !out_src2_switch)
    else $error("wrong pattern while evaluating source one");

  // never a source's signal switch and block switch closed together
  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_src1_switch && out_src1_block) && !(out_src2_switch && out_src2_block))
    else $error("signal and block switch closed together");

  // the skid stage only fills while the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid) && $past(out_stall))
    else $error("input stalled without output back-pressure");

endmodule

bind dual_source_harvest_selector_top dshs_checker u_dshs_checker (.*);
